>>> sv/page_frame_allocator_unit_assert.svh
// ----------------------------------------------------------------------------
// page_frame_allocator_unit_assert.svh
// Assertion macros used by the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAME_ALLOCATOR_UNIT_ASSERT_SVH
`define PAGE_FRAME_ALLOCATOR_UNIT_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define PFA_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("allocator check failed");

// Check that the consequent holds in the cycle after the antecedent.
`define PFA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("allocator check failed");

`endif

>>> sv/pfa_pkg.sv
// ----------------------------------------------------------------------------
// pfa_pkg
// Types, codes and default sizes of the page frame allocator.
// ----------------------------------------------------------------------------
package pfa_pkg;

    // default table size and owner width
    localparam int PAGES_DEF      = 128;
    localparam int OWNER_BITS_DEF = 8;

    // fixed field widths of the channels
    localparam int CMD_W    = 2;
    localparam int OWNER_W  = 8;
    localparam int COUNT_W  = 8;
    localparam int INDEX_W  = 7;
    localparam int STATUS_W = 2;
    localparam int FREE_W   = 8;
    localparam int PROC_W   = 16;

    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_FREE    = 2'd1,
        CMD_INSPECT = 2'd2
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_NOSPACE = 2'd1,
        ST_NOOWNER = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_INSPECT,
        S_DONE
    } t_state;

endpackage

>>> sv/pfa_if.sv
// ----------------------------------------------------------------------------
// pfa_req_if / pfa_rsp_if
// Valid/ready channels for allocator commands and results.
// ----------------------------------------------------------------------------
interface pfa_req_if;
    import pfa_pkg::*;

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [OWNER_W-1:0] owner_id;
    logic [COUNT_W-1:0] page_count;
    logic [INDEX_W-1:0] page_index;

    modport source (output valid, command, owner_id, page_count, page_index, input ready);
    modport sink   (input valid, command, owner_id, page_count, page_index, output ready);
endinterface

interface pfa_rsp_if;
    import pfa_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [FREE_W-1:0]   free_pages;
    logic [PROC_W-1:0]   process_count;
    logic                frame_used;
    logic [OWNER_W-1:0]  frame_owner;

    modport source (output valid, status, free_pages, process_count, frame_used,
                    frame_owner, input ready);
    modport sink   (input valid, status, free_pages, process_count, frame_used,
                    frame_owner, output ready);
endinterface

>>> sv/pfa_ram.sv
// ----------------------------------------------------------------------------
// pfa_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pfa_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> sv/page_frame_allocator_unit.sv
// ----------------------------------------------------------------------------
// page_frame_allocator_unit
// First-fit page frame allocator over a RAM of used marks and owner ids.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries one command word: allocate (owner, count), free (owner) or
//   inspect (frame index). o_rsp returns one result word per command with the
//   status, the free frame count, the live process count and, for inspect,
//   the frame's used mark and owner.
//   Allocate and free walk the frame RAM one entry per cycle through a single
//   read port, writing each entry back in the cycle after its read, and then
//   load the result. Inspect reads one entry; an allocate larger than the free
//   count and an unused code go straight to the result.
//   One command is in work at a time; i_req.ready is high only while idle.
//   After reset the block clears all PAGES RAM entries before it takes the
//   first command. The result sits in an output register: a stalled receiver
//   holds it there, the next command is still taken, and its result waits
//   until the register is taken.
// ----------------------------------------------------------------------------
module page_frame_allocator_unit #(
    parameter int PAGES      = pfa_pkg::PAGES_DEF,
    parameter int OWNER_BITS = pfa_pkg::OWNER_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    pfa_req_if.sink        i_req,
    pfa_rsp_if.source      o_rsp
);
    import pfa_pkg::*;

    localparam int AW = $clog2(PAGES);
    localparam int FW = $clog2(PAGES + 1);
    localparam int CW = (FW > COUNT_W) ? FW : COUNT_W;
    localparam int DW = OWNER_BITS + 1;
    localparam int XW = AW + INDEX_W + 1;

    t_state r_state, n_state;

    logic [AW:0]            r_addr, n_addr;
    logic                   r_rd_vld, n_rd_vld;
    logic [AW-1:0]          r_rd_addr, n_rd_addr;
    t_cmd                   r_cmd, n_cmd;
    logic [OWNER_BITS-1:0]  r_who, n_who;
    logic [COUNT_W-1:0]     r_want, n_want;
    logic                   r_idx_ok, n_idx_ok;
    logic [FW-1:0]          r_got, n_got;
    logic [FW-1:0]          r_free, n_free;
    logic [PROC_W-1:0]      r_live, n_live;
    logic                   r_found, n_found;
    t_status                r_st, n_st;
    logic                   r_res_used, n_res_used;
    logic [OWNER_W-1:0]     r_res_own, n_res_own;

    logic                   r_o_valid;
    t_status                r_o_status;
    logic [FREE_W-1:0]      r_o_free;
    logic [PROC_W-1:0]      r_o_count;
    logic                   r_o_used;
    logic [OWNER_W-1:0]     r_o_owner;

    logic                   ram_we;
    logic [AW-1:0]          ram_waddr;
    logic [DW-1:0]          ram_wdata;
    logic [AW-1:0]          ram_raddr;
    logic [DW-1:0]          ram_rdata;

    logic                   accept;
    logic                   out_load;
    logic                   scan_issue;
    logic                   scan_end;
    logic                   clear_last;
    logic                   too_many;
    logic [XW-1:0]          idx_ext;
    logic [15:0]            who_ext;
    logic [15:0]            own_ext;
    logic [CW-1:0]          free_ext;
    logic                   rd_used;
    logic [OWNER_BITS-1:0]  rd_owner;

    pfa_ram #(
        .WIDTH (DW),
        .DEPTH (PAGES)
    ) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // handshake and helper terms
    assign i_req.ready = (r_state == S_IDLE);
    assign accept      = i_req.valid && i_req.ready;
    assign out_load    = (r_state == S_DONE) && (!r_o_valid || o_rsp.ready);
    assign scan_issue  = (r_addr != (AW + 1)'(PAGES));
    assign scan_end    = (r_state == S_SCAN) && !scan_issue && !r_rd_vld;
    assign clear_last  = (r_addr == (AW + 1)'(PAGES - 1));
    assign too_many    = CW'(i_req.page_count) > CW'(r_free);
    assign idx_ext     = XW'(i_req.page_index);
    assign who_ext     = 16'(i_req.owner_id);
    assign rd_used     = ram_rdata[OWNER_BITS];
    assign rd_owner    = ram_rdata[OWNER_BITS-1:0];
    assign own_ext     = 16'(rd_owner);
    assign free_ext    = CW'(r_free);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    unique case (t_cmd'(i_req.command))
                        CMD_ALLOC:   n_state = too_many ? S_DONE : S_SCAN;
                        CMD_FREE:    n_state = S_SCAN;
                        CMD_INSPECT: n_state = S_INSPECT;
                        default:     n_state = S_DONE;
                    endcase
                end
            end
            S_SCAN: begin
                if (scan_end) begin
                    n_state = S_DONE;
                end
            end
            S_INSPECT: n_state = S_DONE;
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath: clear sweep, command capture, read-modify-write scan
    always_comb begin
        n_addr     = r_addr;
        n_rd_vld   = 1'b0;
        n_rd_addr  = r_rd_addr;
        n_cmd      = r_cmd;
        n_who      = r_who;
        n_want     = r_want;
        n_idx_ok   = r_idx_ok;
        n_got      = r_got;
        n_free     = r_free;
        n_live     = r_live;
        n_found    = r_found;
        n_st       = r_st;
        n_res_used = r_res_used;
        n_res_own  = r_res_own;
        ram_we     = 1'b0;
        ram_waddr  = r_rd_addr;
        ram_wdata  = '0;
        ram_raddr  = r_addr[AW-1:0];

        unique case (r_state)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_addr[AW-1:0];
                n_addr    = clear_last ? '0 : r_addr + 1'b1;
            end
            S_IDLE: begin
                ram_raddr = idx_ext[AW-1:0];
                if (accept) begin
                    n_cmd      = t_cmd'(i_req.command);
                    n_who      = who_ext[OWNER_BITS-1:0];
                    n_want     = i_req.page_count;
                    n_idx_ok   = idx_ext < XW'(PAGES);
                    n_addr     = '0;
                    n_got      = '0;
                    n_found    = 1'b0;
                    n_res_used = 1'b0;
                    n_res_own  = '0;
                    n_st       = ((t_cmd'(i_req.command) == CMD_ALLOC) && too_many)
                                 ? ST_NOSPACE : ST_OK;
                end
            end
            S_SCAN: begin
                // issue the next read
                n_rd_vld  = scan_issue;
                n_rd_addr = r_addr[AW-1:0];
                if (scan_issue) begin
                    n_addr = r_addr + 1'b1;
                end
                // modify and write back the entry read last cycle
                if (r_rd_vld) begin
                    if (r_cmd == CMD_ALLOC) begin
                        if (!rd_used && (CW'(r_got) < CW'(r_want))) begin
                            ram_we    = 1'b1;
                            ram_wdata = {1'b1, r_who};
                            n_got     = r_got + 1'b1;
                            n_free    = r_free - 1'b1;
                        end
                    end else begin
                        if (rd_used && (rd_owner == r_who)) begin
                            ram_we    = 1'b1;
                            ram_wdata = '0;
                            n_free    = r_free + 1'b1;
                            n_found   = 1'b1;
                        end
                    end
                end
                // settle the process count and status
                if (scan_end) begin
                    if (r_cmd == CMD_ALLOC) begin
                        if (r_live != '1) begin
                            n_live = r_live + 1'b1;
                        end
                        n_st = ST_OK;
                    end else if (r_found) begin
                        if (r_live != '0) begin
                            n_live = r_live - 1'b1;
                        end
                        n_st = ST_OK;
                    end else begin
                        n_st = ST_NOOWNER;
                    end
                end
            end
            S_INSPECT: begin
                n_res_used = r_idx_ok & rd_used;
                n_res_own  = r_idx_ok ? own_ext[OWNER_W-1:0] : '0;
            end
            S_DONE: begin
                n_rd_vld = 1'b0;
            end
            default: begin
                n_rd_vld = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_addr   <= '0;
            r_rd_vld <= 1'b0;
            r_free   <= FW'(PAGES);
            r_live   <= '0;
        end else begin
            r_state  <= n_state;
            r_addr   <= n_addr;
            r_rd_vld <= n_rd_vld;
            r_free   <= n_free;
            r_live   <= n_live;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_rd_addr  <= n_rd_addr;
        r_cmd      <= n_cmd;
        r_who      <= n_who;
        r_want     <= n_want;
        r_idx_ok   <= n_idx_ok;
        r_got      <= n_got;
        r_found    <= n_found;
        r_st       <= n_st;
        r_res_used <= n_res_used;
        r_res_own  <= n_res_own;
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (out_load) begin
            r_o_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_status <= r_st;
            r_o_free   <= free_ext[FREE_W-1:0];
            r_o_count  <= r_live;
            r_o_used   <= r_res_used;
            r_o_owner  <= r_res_own;
        end
    end

    assign o_rsp.valid         = r_o_valid;
    assign o_rsp.status        = r_o_status;
    assign o_rsp.free_pages    = r_o_free;
    assign o_rsp.process_count = r_o_count;
    assign o_rsp.frame_used    = r_o_used;
    assign o_rsp.frame_owner   = r_o_owner;

`include "page_frame_allocator_unit_assert.svh"

    // free count stays within the table
    `PFA_ASSERT_SAME(a_free_range, i_clk, i_rst_n, 1'b1, r_free <= FW'(PAGES))
    // an allocate scan never claims more frames than asked for
    `PFA_ASSERT_SAME(a_got_bound, i_clk, i_rst_n, (r_state == S_SCAN) && (r_cmd == CMD_ALLOC),
                     CW'(r_got) <= CW'(r_want))
    // the RAM is never written while idle or waiting on the output
    `PFA_ASSERT_SAME(a_no_idle_write, i_clk, i_rst_n,
                     (r_state == S_IDLE) || (r_state == S_DONE), !ram_we)
    // an accepted command leaves the idle state
    `PFA_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, accept, r_state != S_IDLE)

endmodule
